// ----- sv/olc_pkg.sv -----
// Shared types and constants for the occupancy light controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package olc_pkg;

    localparam int unsigned LIGHT_W   = 10;
    localparam int unsigned NOW_W     = 32;
    localparam int unsigned TIMEOUT_W = 20;
    localparam int unsigned CFG_W     = 20;
    localparam int unsigned MODE_W    = 2;

    localparam int unsigned BLINK_HALF_MS = 500;

    // Blink phase is bit 0 of now / BLINK_HALF_MS, done as a reciprocal multiply:
    // shift = N + ceil(log2 d), recip = ceil(2^shift / d), exact for every N-bit now.
    localparam int unsigned BLINK_SHIFT = NOW_W + $clog2(BLINK_HALF_MS);
    localparam int unsigned RECIP_W     = NOW_W + 1;
    localparam int unsigned PROD_W      = NOW_W + RECIP_W;
    localparam logic [RECIP_W-1:0] BLINK_RECIP = RECIP_W'(
        ((64'd1 << BLINK_SHIFT) + 64'(BLINK_HALF_MS) - 64'd1) / 64'(BLINK_HALF_MS));

    localparam logic [LIGHT_W-1:0]   LIGHT_LIMIT_RST    = LIGHT_W'(5);
    localparam logic [TIMEOUT_W-1:0] PREOFF_TIMEOUT_RST = TIMEOUT_W'(10000);

    // Register indexes on the configuration port
    localparam logic CFG_LIGHT_LIMIT    = 1'b0;
    localparam logic CFG_PREOFF_TIMEOUT = 1'b1;

    // Mode codes as seen on the result port
    localparam logic [MODE_W-1:0] MODE_IDLE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MONITOR  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PREOFF   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_DISABLED = 2'd3;

    typedef enum logic [3:0] {
        MD_IDLE     = 4'b0001,
        MD_MONITOR  = 4'b0010,
        MD_PREOFF   = 4'b0100,
        MD_DISABLED = 4'b1000
    } t_mode;

    typedef enum logic [2:0] {
        PH_LOW_A = 3'b001,
        PH_HIGH  = 3'b010,
        PH_LOW_B = 3'b100
    } t_phase;

    typedef struct packed {
        logic [LIGHT_W-1:0] light_level;
        logic               hall_level;
        logic               pir_level;
        logic               radar_level;
        logic [NOW_W-1:0]   now_ms;
    } t_sample;

    typedef struct packed {
        logic [LIGHT_W-1:0]   light_limit;
        logic [TIMEOUT_W-1:0] preoff_timeout_ms;
    } t_cfg;

    function automatic logic [MODE_W-1:0] mode_code(input t_mode m);
        logic [MODE_W-1:0] c;
        c = MODE_IDLE;
        unique case (m)
            MD_IDLE:     c = MODE_IDLE;
            MD_MONITOR:  c = MODE_MONITOR;
            MD_PREOFF:   c = MODE_PREOFF;
            MD_DISABLED: c = MODE_DISABLED;
            default:     c = MODE_IDLE;
        endcase
        return c;
    endfunction

endpackage

// ----- sv/olc_blink.sv -----
// Pre-off blink phase: bit 0 of now_ms / BLINK_HALF_MS by reciprocal multiply.
// Depends on olc_pkg.
`timescale 1ns / 1ps

module olc_blink
    import olc_pkg::*;
(
    input  logic [NOW_W-1:0] i_now_ms,
    output logic             o_blink
);

    logic [PROD_W-1:0] w_prod;

    assign w_prod  = PROD_W'(i_now_ms) * PROD_W'(BLINK_RECIP);
    assign o_blink = w_prod[BLINK_SHIFT];

endmodule

// ----- sv/olc_ctrl.sv -----
// Controller state (mode, hall pattern detector, pre-off start time) and its
// next-state logic. Depends on olc_pkg.
`timescale 1ns / 1ps

module olc_ctrl
    import olc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  t_sample           i_sample,
    input  t_cfg              i_cfg,
    input  logic              i_blink,
    output logic              o_lamp_on,
    output logic [MODE_W-1:0] o_mode
);

    t_mode             r_mode,  n_mode;
    t_phase            r_phase, n_phase;
    logic [NOW_W-1:0]  r_start, n_start;
    logic              w_lit;
    logic              w_expired;
    logic [NOW_W-1:0]  w_elapsed;

    assign w_lit     = i_sample.light_level > i_cfg.light_limit;
    assign w_elapsed = i_sample.now_ms - r_start;     // wraps mod 2^32
    assign w_expired = w_elapsed >= NOW_W'(i_cfg.preoff_timeout_ms);

    always_comb begin
        n_mode    = r_mode;
        n_phase   = r_phase;
        n_start   = r_start;
        o_lamp_on = 1'b0;
        unique case (r_mode)
            MD_IDLE: begin
                if (w_lit) n_mode = MD_MONITOR;
            end
            MD_MONITOR: begin
                o_lamp_on = 1'b1;
                if (!w_lit) begin
                    n_mode = MD_IDLE;
                end else begin
                    // hall detector only moves while lit in monitor
                    unique case (r_phase)
                        PH_HIGH: begin
                            if (!i_sample.hall_level) n_phase = PH_LOW_B;
                        end
                        PH_LOW_B: begin
                            if (i_sample.hall_level) begin
                                n_phase = PH_LOW_A;
                                n_mode  = MD_PREOFF;
                                n_start = i_sample.now_ms;
                            end
                        end
                        default: begin
                            n_phase = i_sample.hall_level ? PH_HIGH : PH_LOW_A;
                        end
                    endcase
                end
            end
            MD_PREOFF: begin
                o_lamp_on = i_blink;
                // motion wins over an elapsed timeout
                if (i_sample.pir_level || i_sample.radar_level) begin
                    n_mode = MD_MONITOR;
                end else if (w_expired) begin
                    n_mode = MD_DISABLED;
                end
            end
            default: begin
                if (!w_lit) n_mode = MD_IDLE;
            end
        endcase
    end

    assign o_mode = mode_code(n_mode);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MD_IDLE;
            r_phase <= PH_LOW_A;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_phase <= n_phase;
        end
    end

    // only read in pre-off, which is entered by writing it
    always_ff @(posedge i_clk) begin
        if (i_step) r_start <= n_start;
    end

endmodule

// ----- sv/occupancy_light_controller_core.sv -----
// Occupancy light controller: one sensor sample in, one lamp/mode result out.
// One item per clock is sustained while i_stall stays low; a result is presented
// once its item has passed the input register and then the result register, and is
// taken at an edge where i_stall is low. The rate is set by the update of the mode
// register, which sits beside a 32x33 reciprocal multiplier for the pre-off blink
// phase between the two registers. While a result waits on i_stall one further item
// can still enter the input register; after that o_stall follows i_stall.
// Configuration writes take effect on the next clock and are meant for idle periods only.
// Depends on olc_pkg, olc_blink, olc_ctrl.
`timescale 1ns / 1ps

module occupancy_light_controller_core
    import olc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // sample channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [LIGHT_W-1:0]   i_light_level,
    input  logic                 i_hall_level,
    input  logic                 i_pir_level,
    input  logic                 i_radar_level,
    input  logic [NOW_W-1:0]     i_now_ms,
    // result channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_lamp_on,
    output logic [MODE_W-1:0]    o_mode,
    // configuration
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    logic              r_in_valid;
    t_sample           r_in;
    logic              r_out_valid;
    logic              r_out_lamp;
    logic [MODE_W-1:0] r_out_mode;
    t_cfg              r_cfg;

    logic              w_step;
    logic              w_in_ready;
    logic              w_blink;
    logic              w_lamp;
    logic [MODE_W-1:0] w_mode;

    assign w_step     = r_in_valid && (!r_out_valid || !i_stall);
    assign w_in_ready = !r_in_valid || w_step;
    assign o_stall    = !w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_valid) begin
            r_in.light_level <= i_light_level;
            r_in.hall_level  <= i_hall_level;
            r_in.pir_level   <= i_pir_level;
            r_in.radar_level <= i_radar_level;
            r_in.now_ms      <= i_now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.light_limit       <= LIGHT_LIMIT_RST;
            r_cfg.preoff_timeout_ms <= PREOFF_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LIGHT_LIMIT:    r_cfg.light_limit       <= i_cfg_wdata[LIGHT_W-1:0];
                CFG_PREOFF_TIMEOUT: r_cfg.preoff_timeout_ms <= i_cfg_wdata[TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    olc_blink u_blink (
        .i_now_ms (r_in.now_ms),
        .o_blink  (w_blink)
    );

    olc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_sample  (r_in),
        .i_cfg     (r_cfg),
        .i_blink   (w_blink),
        .o_lamp_on (w_lamp),
        .o_mode    (w_mode)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_lamp <= w_lamp;
            r_out_mode <= w_mode;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_lamp_on = r_out_lamp;
    assign o_mode    = r_out_mode;

endmodule

// ----- sv/olc_checker.sv -----
// Port-level checks for occupancy_light_controller_core, bound to the top level.
// Depends on olc_pkg.
`timescale 1ns / 1ps

module olc_checker
    import olc_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input logic              o_lamp_on,
    input logic [MODE_W-1:0] o_mode
);

    logic              w_out_acc;
    logic [MODE_W-1:0] r_last_mode;

    assign w_out_acc = o_valid && !i_stall;

    // mode of the last delivered item, i.e. the state before the next one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_mode <= MODE_IDLE;
        end else if (w_out_acc) begin
            r_last_mode <= o_mode;
        end
    end

    a_idle_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && r_last_mode == MODE_IDLE) |->
            (o_mode == MODE_IDLE || o_mode == MODE_MONITOR))
        else $error("idle left for a mode other than monitor");

    a_lamp_by_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && r_last_mode != MODE_PREOFF) |->
            (o_lamp_on == (r_last_mode == MODE_MONITOR)))
        else $error("lamp does not follow the previous mode");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while the result side can move");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_mode) && $stable(o_lamp_on)))
        else $error("stalled result changed");

endmodule

bind occupancy_light_controller_core olc_checker u_olc_checker (.*);

// ----- tb/tb.sv -----
// Self-checking bench for occupancy_light_controller_core: a lamp/mode predictor
// checks every result, under random idling on both channels and several thresholds.
// Depends on olc_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb;
    import olc_pkg::*;

    typedef struct packed {
        logic              lamp_on;
        logic [MODE_W-1:0] mode;
    } t_lamp_mode;

    // Tracks controller state; each accepted sample queues its lamp/mode result
    class lamp_mode_tracker;
        logic [LIGHT_W-1:0]   thr;
        logic [TIMEOUT_W-1:0] tmo;
        logic [MODE_W-1:0]    mode;
        t_phase               phase;
        logic [NOW_W-1:0]     start_ms;
        t_lamp_mode           due_results[$];
        int                   errors;
        int                   n_checked;
        int                   visits[4];

        function new();
            thr       = LIGHT_LIMIT_RST;
            tmo       = PREOFF_TIMEOUT_RST;
            mode      = MODE_IDLE;
            phase     = PH_LOW_A;
            start_ms  = '0;
            errors    = 0;
            n_checked = 0;
            foreach (visits[i]) visits[i] = 0;
        endfunction

        function void set_reg(logic idx, logic [CFG_W-1:0] d);
            if (idx == CFG_LIGHT_LIMIT)
                thr = d[LIGHT_W-1:0];
            else
                tmo = d[TIMEOUT_W-1:0];
        endfunction

        // true when high-low-high completes
        function logic hall_step(logic lvl);
            logic done;
            done = 1'b0;
            case (phase)
                PH_HIGH: if (!lvl) phase = PH_LOW_B;
                PH_LOW_B: begin
                    if (lvl) begin
                        phase = PH_LOW_A;
                        done  = 1'b1;
                    end
                end
                default: phase = lvl ? PH_HIGH : PH_LOW_A;
            endcase
            return done;
        endfunction

        function void note_sample(t_sample s);
            t_lamp_mode       e;
            logic             lit;
            logic [NOW_W-1:0] elapsed;
            logic [NOW_W-1:0] quot;
            lit       = s.light_level > thr;
            elapsed   = s.now_ms - start_ms;
            quot      = s.now_ms / NOW_W'(BLINK_HALF_MS);
            e.lamp_on = 1'b0;
            // lamp follows the mode held before the step
            case (mode)
                MODE_IDLE: if (lit) mode = MODE_MONITOR;
                MODE_MONITOR: begin
                    e.lamp_on = 1'b1;
                    if (!lit) begin
                        mode = MODE_IDLE;
                    end else if (hall_step(s.hall_level)) begin
                        mode     = MODE_PREOFF;
                        start_ms = s.now_ms;
                    end
                end
                MODE_PREOFF: begin
                    e.lamp_on = quot[0];
                    if (s.pir_level || s.radar_level)
                        mode = MODE_MONITOR;
                    else if (elapsed >= NOW_W'(tmo))
                        mode = MODE_DISABLED;
                end
                default: if (!lit) mode = MODE_IDLE;
            endcase
            e.mode = mode;
            due_results.push_back(e);
            visits[mode]++;
        endfunction

        function void check_result(logic lamp, logic [MODE_W-1:0] m);
            t_lamp_mode e;
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result lamp_on %0b mode %0d", $time, lamp, m);
                errors++;
                return;
            end
            e = due_results.pop_front();
            n_checked++;
            if (lamp !== e.lamp_on) begin
                $display("%0t: lamp_on expected %0b got %0b", $time, e.lamp_on, lamp);
                errors++;
            end
            if (m !== e.mode) begin
                $display("%0t: mode expected %0d got %0d", $time, e.mode, m);
                errors++;
            end
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    localparam int STALL_LIMIT = 3000;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_valid       = 1'b0;
    logic               o_stall;
    logic [LIGHT_W-1:0] i_light_level = '0;
    logic               i_hall_level  = 1'b0;
    logic               i_pir_level   = 1'b0;
    logic               i_radar_level = 1'b0;
    logic [NOW_W-1:0]   i_now_ms      = '0;
    logic               o_valid;
    logic               i_stall       = 1'b0;
    logic               o_lamp_on;
    logic [MODE_W-1:0]  o_mode;
    logic               i_cfg_we      = 1'b0;
    logic               i_cfg_idx     = CFG_LIGHT_LIMIT;
    logic [CFG_W-1:0]   i_cfg_wdata   = '0;

    lamp_mode_tracker sb = new();

    int               send_pct  = 0;
    int               recv_pct  = 0;
    int               n_sent    = 0;
    int               n_configs = 0;
    int               quiet     = 0;
    logic [NOW_W-1:0] clock_ms  = '0;

    occupancy_light_controller_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_light_level (i_light_level),
        .i_hall_level  (i_hall_level),
        .i_pir_level   (i_pir_level),
        .i_radar_level (i_radar_level),
        .i_now_ms      (i_now_ms),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_lamp_on     (o_lamp_on),
        .o_mode        (o_mode),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99, 0) < recv_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall)
            sb.check_result(o_lamp_on, o_mode);
    end

    // watchdog: cycles with no item moving on either channel
    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic offer_sample(input logic [LIGHT_W-1:0] lt, input logic h, input logic p,
                                input logic r, input logic [NOW_W-1:0] t);
        t_sample s;
        if (n_sent < 460) begin
            send_pct = 14;
            recv_pct = 79;
        end else if (n_sent < 920) begin
            send_pct = 79;
            recv_pct = 14;
        end else begin
            send_pct = 0;
            recv_pct = 0;
        end
        while ($urandom_range(99, 0) < send_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_light_level <= lt;
        i_hall_level  <= h;
        i_pir_level   <= p;
        i_radar_level <= r;
        i_now_ms      <= t;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        s.light_level = lt;
        s.hall_level  = h;
        s.pir_level   = p;
        s.radar_level = r;
        s.now_ms      = t;
        sb.note_sample(s);
        n_sent++;
    endtask

    // registers are only touched with the pipe empty
    task automatic write_regs(input logic [LIGHT_W-1:0] thr, input logic [TIMEOUT_W-1:0] tmo);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_LIGHT_LIMIT;
        i_cfg_wdata <= CFG_W'(thr);
        @(posedge i_clk);
        sb.set_reg(CFG_LIGHT_LIMIT, CFG_W'(thr));
        i_cfg_idx   <= CFG_PREOFF_TIMEOUT;
        i_cfg_wdata <= CFG_W'(tmo);
        @(posedge i_clk);
        sb.set_reg(CFG_PREOFF_TIMEOUT, CFG_W'(tmo));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        n_configs++;
    endtask

    function automatic logic [LIGHT_W-1:0] bright_level();
        if (sb.thr == '1)
            return '1;
        return LIGHT_W'($urandom_range(1023, int'(sb.thr) + 1));
    endfunction

    function automatic logic [LIGHT_W-1:0] dim_level();
        return LIGHT_W'($urandom_range(int'(sb.thr), 0));
    endfunction

    // Mostly steers towards the hall pattern and the pre-off exits; a few items are noise
    task automatic random_sample();
        logic [LIGHT_W-1:0] lt;
        logic               h;
        logic               p;
        logic               r;
        int unsigned        roll;
        roll     = $urandom_range(99, 0);
        lt       = LIGHT_W'($urandom);
        h        = 1'($urandom);
        p        = 1'($urandom);
        r        = 1'($urandom);
        clock_ms = clock_ms + NOW_W'($urandom_range(20, 0));
        if (roll < 8) begin
            if (roll < 3)
                clock_ms = $urandom;
        end else begin
            case (sb.mode)
                MODE_IDLE: lt = (roll < 75) ? bright_level() : dim_level();
                MODE_MONITOR: begin
                    lt = (roll < 94) ? bright_level() : dim_level();
                    if ($urandom_range(4, 0) != 0)
                        h = (sb.phase != PH_HIGH);
                    // park the timestamp just short of the wrap now and then
                    if ($urandom_range(15, 0) == 0)
                        clock_ms = '1 - NOW_W'($urandom_range(3000, 0));
                end
                MODE_PREOFF: begin
                    p        = ($urandom_range(9, 0) == 0);
                    r        = ($urandom_range(9, 0) == 0);
                    clock_ms = clock_ms + NOW_W'($urandom_range(int'(sb.tmo / 2) + 600, 0));
                end
                default: lt = (roll < 55) ? dim_level() : bright_level();
            endcase
        end
        offer_sample(lt, h, p, r, clock_ms);
    endtask

    initial begin
        logic [LIGHT_W-1:0]   thr_set[6];
        logic [TIMEOUT_W-1:0] tmo_set[6];
        int                   n_set[6];
        thr_set = '{10'd0, 10'd1023, 10'd0, 10'd0, 10'd300, 10'd5};
        tmo_set = '{20'd0, 20'hFFFFF, 20'hFFFFF, 20'd0, 20'd20, 20'd10000};
        n_set   = '{260, 60, 260, 260, 260, 260};
        thr_set[3] = LIGHT_W'($urandom_range(1022, 1));
        tmo_set[3] = TIMEOUT_W'($urandom_range(5000, 1));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, reset thresholds (light 5, timeout 10000)
        offer_sample(10'd0,    1'b0, 1'b0, 1'b0, 32'd0);
        offer_sample(10'd5,    1'b1, 1'b1, 1'b1, 32'd1);          // equal to threshold: dark
        offer_sample(10'd6,    1'b0, 1'b0, 1'b0, 32'd2);          // to monitor
        offer_sample(10'd1023, 1'b1, 1'b1, 1'b1, 32'd3);
        offer_sample(10'd500,  1'b0, 1'b0, 1'b0, 32'd4);
        offer_sample(10'd500,  1'b1, 1'b0, 1'b0, 32'd1000);       // pattern done
        offer_sample(10'd500,  1'b0, 1'b0, 1'b0, 32'd1499);       // blink low
        offer_sample(10'd500,  1'b0, 1'b0, 1'b0, 32'd1500);       // blink high
        offer_sample(10'd0,    1'b0, 1'b1, 1'b0, 32'd1600);       // PIR back to monitor
        offer_sample(10'd6,    1'b1, 1'b0, 1'b0, 32'd1700);
        offer_sample(10'd0,    1'b0, 1'b0, 1'b0, 32'd1701);       // leave with phase kept
        offer_sample(10'd6,    1'b0, 1'b0, 1'b0, 32'd1702);
        offer_sample(10'd6,    1'b0, 1'b0, 1'b0, 32'd1703);
        offer_sample(10'd6,    1'b1, 1'b0, 1'b0, 32'hFFFF_F000);
        offer_sample(10'd6,    1'b0, 1'b0, 1'b1, 32'h0000_2000);  // radar beats timeout
        offer_sample(10'd6,    1'b1, 1'b0, 1'b0, 32'h0000_2001);
        offer_sample(10'd6,    1'b0, 1'b0, 1'b0, 32'h0000_2002);
        offer_sample(10'd6,    1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF);
        offer_sample(10'd1023, 1'b1, 1'b0, 1'b0, 32'h0000_270E);  // one short across wrap
        offer_sample(10'd1023, 1'b0, 1'b0, 1'b0, 32'h0000_270F);  // exactly the timeout
        offer_sample(10'd1023, 1'b1, 1'b1, 1'b1, 32'h0000_3000);
        offer_sample(10'd5,    1'b0, 1'b0, 1'b0, 32'h0000_3001);
        clock_ms = 32'h0000_3001;

        for (int k = 0; k < 6; k++) begin
            write_regs(thr_set[k], tmo_set[k]);
            repeat (n_set[k]) random_sample();
        end

        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("%0d samples, %0d results checked, %0d register settings", n_sent,
                 sb.n_checked, n_configs + 1);
        $display("modes reached: idle %0d monitor %0d pre-off %0d disabled %0d",
                 sb.visits[0], sb.visits[1], sb.visits[2], sb.visits[3]);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/olc_pkg.sv
sv/olc_blink.sv
sv/olc_ctrl.sv
sv/occupancy_light_controller_core.sv
sv/olc_checker.sv
tb/tb.sv
